// File: sv/vending_controller_defines.svh
// Assertion macros shared by the RTL.
`ifndef VENDING_CONTROLLER_DEFINES_SVH
`define VENDING_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, held off while reset is asserted.
`define VC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("vending_controller: check failed");

// Clocked check that also holds during reset.
`define VC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("vending_controller: check failed");

`else

`define VC_ASSERT(lbl, clk, rst_n, prop)
`define VC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: sv/vc_pkg.sv
package vc_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int FULL_STOCK  = 50;
	localparam int NUM_PRICES  = 8;
	localparam int TOTAL_FULL  = NUM_SLOTS * FULL_STOCK;

	localparam int CMD_W       = 3;
	localparam int SLOT_W      = 3;
	localparam int AMOUNT_W    = 10;
	localparam int PRICE_W     = 10;
	localparam int STATUS_W    = 3;
	localparam int MODE_W      = 2;
	localparam int STOCK_W     = 6;
	localparam int TOTAL_W     = $clog2(TOTAL_FULL + 1);
	localparam int STOCK_IDX_W = $clog2(NUM_SLOTS);
	localparam int SLOT_EXT_W  = 5;
	localparam int PRICE_IDX_W = $clog2(NUM_PRICES);
	localparam int PADDR_W     = PRICE_IDX_W + 2;
	localparam int PDATA_W     = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_BUY    = 3'd0,
		CMD_SELECT = 3'd1,
		CMD_PAY    = 3'd2,
		CMD_CANCEL = 3'd3,
		CMD_REFILL = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DISPENSED = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_REFILLED  = 3'd3,
		ST_NOSTOCK   = 3'd4,
		ST_SHORT     = 3'd5,
		ST_INVALID   = 3'd6,
		ST_EMPTY     = 3'd7
	} status_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE    = 2'd0,
		MODE_CHOOSE  = 2'd1,
		MODE_COLLECT = 2'd2
	} mode_t;

	typedef logic [PRICE_W-1:0] price_t;

	localparam price_t PRICE_RESET [NUM_PRICES] = '{
		10'd30, 10'd30, 10'd50, 10'd20, 10'd20, 10'd30, 10'd25, 10'd30
	};

endpackage

// File: sv/vending_controller.sv
// vending_controller: one user command in, one result out, per transfer.
// The accepted command is held in the input register (stage 1), then moves
// into the result register, whose output transfer follows; the state
// registers update at the same edge as the result register loads.
// One command per cycle while out_ready keeps the result register draining;
// the stock/total/mode update is a read-modify-write, which sets the rate.
// Reset (arst_n low, asynchronous): mode idle, chosen slot 0, full stock in
// every slot, total at full, prices at their defaults, both stages empty.
`include "vending_controller_defines.svh"

module vending_controller
	import vc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [SLOT_W-1:0]    drink_index,
	input  logic [AMOUNT_W-1:0]  amount,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [MODE_W-1:0]    mode_now,
	output logic [SLOT_W-1:0]    drink_out,
	output logic [PRICE_W-1:0]   change,

	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	// ------------------------------------------------------------------
	// Price registers on the APB side. Writes land in the access phase;
	// reads return the addressed price zero-extended.
	// ------------------------------------------------------------------
	price_t                 price_q [NUM_PRICES];
	logic [PRICE_IDX_W-1:0] cfg_idx;
	logic                   cfg_we;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_we  = psel & penable & pwrite & pready;
	assign prdata  = {{(PDATA_W-PRICE_W){1'b0}}, price_q[cfg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRICES; i++) begin
				price_q[i] <= PRICE_RESET[i];
			end
		end else if (cfg_we) begin
			price_q[cfg_idx] <= pwdata[PRICE_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Flow control. Stage 1 holds the accepted command; it advances into
	// the result register whenever that register is empty or being drained.
	// A waiting result blocks a new input transfer only once stage 1 is
	// also occupied.
	// ------------------------------------------------------------------
	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [AMOUNT_W-1:0] amount_s1;
	logic                out_valid_q;
	logic                advance;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of stage 1: capture on every input transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= command;
			slot_s1   <= drink_index;
			amount_s1 <= amount;
		end
	end

	// ------------------------------------------------------------------
	// Machine state.
	// ------------------------------------------------------------------
	mode_t              mode_q;
	mode_t              mode_d;
	logic [SLOT_W-1:0]  chosen_q;
	logic [STOCK_W-1:0] stock_q [NUM_SLOTS];
	logic [TOTAL_W-1:0] total_q;

	// Stock is read at one place: the chosen slot while collecting, the
	// requested slot otherwise. Slots past the end read as empty.
	logic [SLOT_EXT_W-1:0]  sel_ext;
	logic [SLOT_EXT_W-1:0]  chosen_ext;
	logic [SLOT_EXT_W-1:0]  rd_ext;
	logic                   sel_in_range;
	logic                   rd_in_range;
	logic [STOCK_IDX_W-1:0] rd_idx;
	logic [STOCK_W-1:0]     rd_stock;
	logic                   rd_stock_nz;
	logic                   total_nz;
	price_t                 cur_price;
	logic                   pay_ok;

	assign sel_ext      = {{(SLOT_EXT_W-SLOT_W){1'b0}}, slot_s1};
	assign chosen_ext   = {{(SLOT_EXT_W-SLOT_W){1'b0}}, chosen_q};
	assign sel_in_range = (sel_ext < SLOT_EXT_W'(NUM_SLOTS));
	assign rd_ext       = (mode_q == MODE_COLLECT) ? chosen_ext : sel_ext;
	assign rd_in_range  = (rd_ext < SLOT_EXT_W'(NUM_SLOTS));
	assign rd_idx       = rd_ext[STOCK_IDX_W-1:0];
	assign rd_stock     = rd_in_range ? stock_q[rd_idx] : '0;
	assign rd_stock_nz  = (rd_stock != '0);
	assign total_nz     = (total_q != '0);
	assign cur_price    = price_q[chosen_q[PRICE_IDX_W-1:0]];
	assign pay_ok       = (amount_s1 >= cur_price);

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_CHOOSE: begin
				if (cmd_s1 == CMD_CANCEL) begin
					mode_d = MODE_IDLE;
				end else if (cmd_s1 == CMD_SELECT && sel_in_range && rd_stock_nz) begin
					mode_d = MODE_COLLECT;
				end
			end
			MODE_COLLECT: begin
				if (cmd_s1 == CMD_CANCEL) begin
					mode_d = MODE_IDLE;
				end else if (cmd_s1 == CMD_PAY && pay_ok) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				// Idle, and the unused code, which behaves as idle.
				mode_d = (total_nz && cmd_s1 == CMD_BUY) ? MODE_CHOOSE : MODE_IDLE;
			end
		endcase
	end

	// Result fields and counter actions.
	status_t            status_d;
	logic [SLOT_W-1:0]  drink_d;
	logic [PRICE_W-1:0] change_d;
	logic               dispense;
	logic               refill;
	logic               chosen_we;

	always_comb begin
		status_d  = ST_INVALID;
		drink_d   = '0;
		change_d  = '0;
		dispense  = 1'b0;
		refill    = 1'b0;
		chosen_we = 1'b0;
		case (mode_q)
			MODE_CHOOSE: begin
				if (cmd_s1 == CMD_CANCEL) begin
					status_d = ST_CANCELLED;
				end else if (cmd_s1 == CMD_SELECT && sel_in_range) begin
					drink_d = slot_s1;
					if (rd_stock_nz) begin
						status_d  = ST_ACCEPTED;
						chosen_we = 1'b1;
					end else begin
						status_d = ST_NOSTOCK;
					end
				end
			end
			MODE_COLLECT: begin
				if (cmd_s1 == CMD_CANCEL) begin
					status_d = ST_CANCELLED;
				end else if (cmd_s1 == CMD_PAY) begin
					drink_d = chosen_q;
					if (pay_ok) begin
						status_d = ST_DISPENSED;
						change_d = amount_s1 - cur_price;
						dispense = 1'b1;
					end else begin
						status_d = ST_SHORT;
					end
				end
			end
			default: begin
				if (!total_nz) begin
					if (cmd_s1 == CMD_REFILL) begin
						status_d = ST_REFILLED;
						refill   = 1'b1;
					end else begin
						status_d = ST_EMPTY;
					end
				end else if (cmd_s1 == CMD_BUY) begin
					status_d = ST_ACCEPTED;
				end
			end
		endcase
	end

	// Commit state on each advance. A dispense clears the chosen slot and
	// lowers both counters, each saturating at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			chosen_q <= '0;
			total_q  <= TOTAL_W'(TOTAL_FULL);
			for (int i = 0; i < NUM_SLOTS; i++) begin
				stock_q[i] <= STOCK_W'(FULL_STOCK);
			end
		end else if (advance) begin
			mode_q <= mode_d;
			if (chosen_we) begin
				chosen_q <= slot_s1;
			end else if (dispense) begin
				chosen_q <= '0;
			end
			if (refill) begin
				total_q <= TOTAL_W'(TOTAL_FULL);
				for (int i = 0; i < NUM_SLOTS; i++) begin
					stock_q[i] <= STOCK_W'(FULL_STOCK);
				end
			end else if (dispense) begin
				if (total_nz) begin
					total_q <= total_q - 1'b1;
				end
				if (rd_in_range && rd_stock_nz) begin
					stock_q[rd_idx] <= rd_stock - 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: load on advance, drop valid once the transfer
	// completes, hold while the consumer stalls.
	// ------------------------------------------------------------------
	logic [STATUS_W-1:0] status_q;
	logic [MODE_W-1:0]   mode_now_q;
	logic [SLOT_W-1:0]   drink_q;
	logic [PRICE_W-1:0]  change_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= status_d;
			mode_now_q <= mode_d;
			drink_q    <= drink_d;
			change_q   <= change_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign mode_now  = mode_now_q;
	assign drink_out = drink_q;
	assign change    = change_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	logic [NUM_SLOTS-1:0] stock_nz_vec;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			stock_nz_vec[i] = (stock_q[i] != '0);
		end
	end

	// The total counts what is left in the slots, so zero total means no stock.
	`VC_ASSERT(a_empty_means_no_stock, clk, arst_n, (total_q == '0) |-> (stock_nz_vec == '0))

	// Collecting is entered only for a slot with stock, and nothing drains it there.
	`VC_ASSERT(a_collect_has_stock, clk, arst_n, (mode_q == MODE_COLLECT) |-> rd_stock_nz)

	// A waiting refill result blocks further updates, so the total stays full.
	`VC_ASSERT(a_refill_full, clk, arst_n, (out_valid_q && status_q == ST_REFILLED) |-> (total_q == TOTAL_W'(TOTAL_FULL)))

endmodule
